// ----- design/order_book_level_table_core_defines.svh -----
// Assertion macros for the level table core.
`ifndef ORDER_BOOK_LEVEL_TABLE_CORE_DEFINES_SVH
`define ORDER_BOOK_LEVEL_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OBL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define OBL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/obl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package obl_pkg;

   // table geometry
   localparam int DEPTH   = 32;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int PRICE_W = 32;
   localparam int VOL_W   = 32;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_CHANGE = 2'd1,
      OP_ERASE  = 2'd2,
      OP_DUMP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_PRESENT = 2'd1,
      ST_ABSENT  = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // command broadcast to every cell of one row
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_REMOVE,
      CMD_SET_VOL,
      CMD_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type         cmd;
      logic [PRICE_W-1:0]   key;
      logic [VOL_W-1:0]     volume;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_APPLY,
      S_DUMP
   } state_type;

endpackage

`default_nettype wire

// ----- design/order_book_level_table_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Two sorted level tables (sell ascending, buy descending) of up to DEPTH
// entries each, built as rows of cells that compare the key in parallel and
// shift toward their neighbors. Add, change and erase pass from acceptance
// through a compare state and an update state to the response word, and a
// new request can be taken in the update state as that word loads. A dump
// of n levels returns one word per level, as the row rotates one place per
// word and presents its head; an empty-side dump returns a single word with
// level_valid low. Response words wait in an output register, so a stall on
// the response side holds the block.
module order_book_level_table_core import obl_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic               req_side,
   input  wire logic [PRICE_W-1:0] req_price,
   input  wire logic [VOL_W-1:0]   req_volume,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic                    rsp_level_side,
   output logic [PRICE_W-1:0]      rsp_level_price,
   output logic [VOL_W-1:0]        rsp_level_volume,
   output logic                    rsp_level_valid,
   output logic                    rsp_last
);

`include "order_book_level_table_core_defines.svh"

   state_type          state_ff, state_in;
   op_type             op_ff;
   logic               side_ff;
   logic [PRICE_W-1:0] key_ff;
   logic [VOL_W-1:0]   vol_ff;
   logic [CNT_W-1:0]   sell_count_ff, sell_count_in;
   logic [CNT_W-1:0]   buy_count_ff, buy_count_in;
   logic [CNT_W-1:0]   remain_ff, remain_in;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_side_ff;
   logic [PRICE_W-1:0] rsp_price_ff, rsp_price_in;
   logic [VOL_W-1:0]   rsp_volume_ff, rsp_volume_in;
   logic               rsp_lvalid_ff, rsp_lvalid_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               rsp_load;
   logic               take_req;
   logic               out_free;
   logic               finish;
   logic               go_dump;
   cell_cmd_type       cmd;
   logic               cnt_inc, cnt_dec;

   logic [CNT_W-1:0]   cnt;
   logic               found;
   logic [PRICE_W-1:0] head_price;
   logic [VOL_W-1:0]   head_volume;

   cell_ctl_type       sell_ctl, buy_ctl;
   logic [PRICE_W-1:0] sell_head_price, buy_head_price;
   logic [VOL_W-1:0]   sell_head_volume, buy_head_volume;
   logic               sell_found, buy_found;

   // selected side view
   assign cnt         = side_ff ? buy_count_ff : sell_count_ff;
   assign found       = side_ff ? buy_found : sell_found;
   assign head_price  = side_ff ? buy_head_price : sell_head_price;
   assign head_volume = side_ff ? buy_head_volume : sell_head_volume;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // row controls: only the addressed side moves
   always_comb begin
      sell_ctl.cmd    = side_ff ? CMD_HOLD : cmd;
      sell_ctl.key    = key_ff;
      sell_ctl.volume = vol_ff;
      buy_ctl.cmd     = side_ff ? cmd : CMD_HOLD;
      buy_ctl.key     = key_ff;
      buy_ctl.volume  = vol_ff;
   end

   obl_chain u_sell (
      .clock       (clock),
      .ctl         (sell_ctl),
      .descend     (1'b0),
      .count       (sell_count_ff),
      .head_price  (sell_head_price),
      .head_volume (sell_head_volume),
      .found       (sell_found)
   );

   obl_chain u_buy (
      .clock       (clock),
      .ctl         (buy_ctl),
      .descend     (1'b1),
      .count       (buy_count_ff),
      .head_price  (buy_head_price),
      .head_volume (buy_head_volume),
      .found       (buy_found)
   );

   // sequencer outputs
   always_comb begin
      cmd           = CMD_HOLD;
      cnt_inc       = 1'b0;
      cnt_dec       = 1'b0;
      rsp_load      = 1'b0;
      finish        = 1'b0;
      go_dump       = 1'b0;
      remain_in     = remain_ff;
      rsp_status_in = ST_OK;
      rsp_price_in  = '0;
      rsp_volume_in = '0;
      rsp_lvalid_in = 1'b0;
      rsp_last_in   = 1'b1;
      case (state_ff)
         S_APPLY: begin
            if (op_ff == OP_DUMP && cnt != '0) begin
               go_dump   = 1'b1;
               remain_in = cnt;
            end else if (out_free) begin
               rsp_load = 1'b1;
               finish   = 1'b1;
               case (op_ff)
                  OP_ADD: begin
                     if (found) begin
                        rsp_status_in = ST_PRESENT;
                     end else if (cnt == CNT_W'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        cmd     = CMD_INSERT;
                        cnt_inc = 1'b1;
                     end
                  end
                  OP_CHANGE: begin
                     if (found) cmd = CMD_SET_VOL;
                     else rsp_status_in = ST_ABSENT;
                  end
                  OP_ERASE: begin
                     if (found) begin
                        cmd     = CMD_REMOVE;
                        cnt_dec = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               cmd           = CMD_ROTATE;
               rsp_price_in  = head_price;
               rsp_volume_in = head_volume;
               rsp_lvalid_in = 1'b1;
               rsp_last_in   = (remain_ff == CNT_W'(1));
               remain_in     = remain_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
      req_stall = !(state_ff == S_IDLE || finish);
      take_req  = req_valid && !req_stall;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (take_req) state_in = S_COMPARE;
         end
         S_COMPARE: state_in = S_APPLY;
         S_APPLY: begin
            if (go_dump) state_in = S_DUMP;
            else if (finish) state_in = take_req ? S_COMPARE : S_IDLE;
         end
         S_DUMP: begin
            if (rsp_load && rsp_last_in) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // level counts
   always_comb begin
      sell_count_in = sell_count_ff;
      buy_count_in  = buy_count_ff;
      if (cnt_inc) begin
         if (side_ff) buy_count_in = buy_count_ff + CNT_W'(1);
         else sell_count_in = sell_count_ff + CNT_W'(1);
      end else if (cnt_dec) begin
         if (side_ff) buy_count_in = buy_count_ff - CNT_W'(1);
         else sell_count_in = sell_count_ff - CNT_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sell_count_ff <= '0;
         buy_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sell_count_ff <= sell_count_in;
         buy_count_ff  <= buy_count_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // request and response words
   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      if (take_req) begin
         op_ff   <= op_type'(req_operation);
         side_ff <= req_side;
         key_ff  <= req_price;
         vol_ff  <= req_volume;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_side_ff   <= side_ff;
         rsp_price_ff  <= rsp_price_in;
         rsp_volume_ff <= rsp_volume_in;
         rsp_lvalid_ff <= rsp_lvalid_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_level_side   = rsp_side_ff;
   assign rsp_level_price  = rsp_price_ff;
   assign rsp_level_volume = rsp_volume_ff;
   assign rsp_level_valid  = rsp_lvalid_ff;
   assign rsp_last         = rsp_last_ff;

   // checks
   `OBL_ASSERT_NOW(a_count_bound, 1'b1,
      (sell_count_ff <= CNT_W'(DEPTH)) && (buy_count_ff <= CNT_W'(DEPTH)),
      "level count beyond table depth")
   `OBL_ASSERT_NEXT(a_count_only_on_apply, state_ff != S_APPLY,
      $stable(sell_count_ff) && $stable(buy_count_ff),
      "level count moved outside the update cycle")
   `OBL_ASSERT_NEXT(a_accept_to_compare, take_req, state_ff == S_COMPARE,
      "accepted request did not start a compare")
   `OBL_ASSERT_NOW(a_dump_nonempty, state_ff == S_DUMP,
      remain_ff != '0 && !req_stall == 1'b0,
      "dump running with nothing left or accepting requests")

endmodule

`default_nettype wire

// ----- design/obl_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One level slot: holds a price and volume, compares against the key and
// takes the key, a neighbor's entry or a new volume as the row command says.
module obl_cell import obl_pkg::*; (
   input  wire logic               clock,
   input  wire cell_ctl_type       ctl,
   input  wire logic               descend,
   input  wire logic               occupied,
   input  wire logic               tail,
   input  wire logic               left_lt,
   input  wire logic [PRICE_W-1:0] left_price,
   input  wire logic [VOL_W-1:0]   left_volume,
   input  wire logic [PRICE_W-1:0] right_price,
   input  wire logic [VOL_W-1:0]   right_volume,
   input  wire logic [PRICE_W-1:0] head_price,
   input  wire logic [VOL_W-1:0]   head_volume,
   output logic [PRICE_W-1:0]      price,
   output logic [VOL_W-1:0]        volume,
   output logic                    lt,
   output logic                    eq
);

   logic [PRICE_W-1:0] price_ff, price_in;
   logic [VOL_W-1:0]   volume_ff, volume_in;
   logic               lt_ff, lt_in;
   logic               eq_ff, eq_in;

   // ordering flags: lt means this entry sorts ahead of the key
   always_comb begin
      lt_in = occupied && (descend ? (price_ff > ctl.key) : (price_ff < ctl.key));
      eq_in = occupied && (price_ff == ctl.key);
   end

   // next entry
   always_comb begin
      price_in  = price_ff;
      volume_in = volume_ff;
      case (ctl.cmd)
         CMD_INSERT: begin
            if (!lt_ff) begin
               if (left_lt) begin
                  price_in  = ctl.key;
                  volume_in = ctl.volume;
               end else begin
                  price_in  = left_price;
                  volume_in = left_volume;
               end
            end
         end
         CMD_REMOVE: begin
            if (!lt_ff) begin
               price_in  = right_price;
               volume_in = right_volume;
            end
         end
         CMD_SET_VOL: begin
            if (eq_ff) volume_in = ctl.volume;
         end
         CMD_ROTATE: begin
            if (tail) begin
               price_in  = head_price;
               volume_in = head_volume;
            end else begin
               price_in  = right_price;
               volume_in = right_volume;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      price_ff  <= price_in;
      volume_ff <= volume_in;
      lt_ff     <= lt_in;
      eq_ff     <= eq_in;
   end

   assign price  = price_ff;
   assign volume = volume_ff;
   assign lt     = lt_ff;
   assign eq     = eq_ff;

endmodule

`default_nettype wire

// ----- design/obl_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One side of the book: a row of cells kept sorted, head at cell 0.
module obl_chain import obl_pkg::*; (
   input  wire logic               clock,
   input  wire cell_ctl_type       ctl,
   input  wire logic               descend,
   input  wire logic [CNT_W-1:0]   count,
   output logic [PRICE_W-1:0]      head_price,
   output logic [VOL_W-1:0]        head_volume,
   output logic                    found
);

   logic [PRICE_W-1:0] price_w  [DEPTH];
   logic [VOL_W-1:0]   volume_w [DEPTH];
   logic [DEPTH-1:0]   lt_w;
   logic [DEPTH-1:0]   eq_w;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic               occ;
      logic               is_tail;
      logic               l_lt;
      logic [PRICE_W-1:0] l_price, r_price;
      logic [VOL_W-1:0]   l_volume, r_volume;

      // occupancy follows from the level count
      assign occ     = (CNT_W'(i) < count);
      assign is_tail = (count == CNT_W'(i + 1));

      if (i == 0) begin : g_first
         assign l_lt     = 1'b1;
         assign l_price  = ctl.key;
         assign l_volume = ctl.volume;
      end else begin : g_mid
         assign l_lt     = lt_w[i-1];
         assign l_price  = price_w[i-1];
         assign l_volume = volume_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign r_price  = price_w[i];
         assign r_volume = volume_w[i];
      end else begin : g_inner
         assign r_price  = price_w[i+1];
         assign r_volume = volume_w[i+1];
      end

      obl_cell u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .descend      (descend),
         .occupied     (occ),
         .tail         (is_tail),
         .left_lt      (l_lt),
         .left_price   (l_price),
         .left_volume  (l_volume),
         .right_price  (r_price),
         .right_volume (r_volume),
         .head_price   (price_w[0]),
         .head_volume  (volume_w[0]),
         .price        (price_w[i]),
         .volume       (volume_w[i]),
         .lt           (lt_w[i]),
         .eq           (eq_w[i])
      );
   end

   assign head_price  = price_w[0];
   assign head_volume = volume_w[0];
   assign found       = |eq_w;

endmodule

`default_nettype wire

// ----- sim/tb_order_book_level_table_core.sv -----
`timescale 1ns / 1ps

module tb_order_book_level_table_core;
   import obl_pkg::*;

   // one response word as the block should deliver it
   typedef struct {
      status_type           status;
      logic                 side;
      logic [PRICE_W-1:0]   price;
      logic [VOL_W-1:0]     volume;
      logic                 valid;
      logic                 last;
   } level_word_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_BURSTY
   } stall_mode_type;

   localparam logic SELL = 1'b0;
   localparam logic BUY  = 1'b1;
   localparam int   MAX_MISMATCH_LINES = 40;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_operation = OP_ADD;
   logic               req_side = SELL;
   logic [PRICE_W-1:0] req_price = '0;
   logic [VOL_W-1:0]   req_volume = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic               rsp_level_side;
   logic [PRICE_W-1:0] rsp_level_price;
   logic [VOL_W-1:0]   rsp_level_volume;
   logic               rsp_level_valid;
   logic               rsp_last;

   // shadow copy of both sides, sorted ascending, index 0 = sell, 1 = buy
   logic [PRICE_W-1:0] book_price  [2][DEPTH];
   logic [VOL_W-1:0]   book_volume [2][DEPTH];
   int                 book_count  [2];

   level_word_type     due_words[$];

   int                 error_count = 0;
   int                 items_sent = 0;
   int                 words_checked = 0;
   int                 op_seen [4];
   int                 status_seen [4];
   int                 dump_levels = 0;

   // sender pacing
   bit                 sender_gaps = 1'b0;
   int                 burst_left = 0;

   // receiver stall pattern
   stall_mode_type     stall_mode = STALL_NONE;
   int                 mode_cycles = 0;
   int                 stall_run = 0;

   order_book_level_table_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_side         (req_side),
      .req_price        (req_price),
      .req_volume       (req_volume),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_level_side   (rsp_level_side),
      .rsp_level_price  (rsp_level_price),
      .rsp_level_volume (rsp_level_volume),
      .rsp_level_valid  (rsp_level_valid),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog
   initial begin
      #12_000_000;
      $display("%0t: timeout, %0d words still due", $time, due_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------
   // Expected-word bookkeeping
   // ---------------------------------------------------------------

   task automatic push_word(input status_type status, input logic side,
                            input logic [PRICE_W-1:0] price, input logic [VOL_W-1:0] volume,
                            input logic valid, input logic last);
      level_word_type w;
      w.status = status;
      w.side   = side;
      w.price  = price;
      w.volume = volume;
      w.valid  = valid;
      w.last   = last;
      due_words.push_back(w);
      status_seen[status]++;
   endtask

   // apply one accepted request to the shadow book and queue its words
   task automatic book_apply(input op_type op, input logic side,
                             input logic [PRICE_W-1:0] price, input logic [VOL_W-1:0] volume);
      int         pos;
      int         n;
      int         idx;
      bit         found;
      status_type status;
      n = book_count[side];
      pos = 0;
      while (pos < n && book_price[side][pos] < price) pos++;
      found = (pos < n) && (book_price[side][pos] == price);
      status = ST_OK;
      op_seen[op]++;
      case (op)
         OP_DUMP: begin
            if (n == 0) begin
               push_word(ST_OK, side, '0, '0, 1'b0, 1'b1);
            end
            // buy side reads out highest price first
            for (int i = 0; i < n; i++) begin
               idx = side ? (n - 1 - i) : i;
               push_word(ST_OK, side, book_price[side][idx], book_volume[side][idx], 1'b1,
                         i == n - 1);
               dump_levels++;
            end
         end
         OP_ADD: begin
            // duplicate check wins over full check
            if (found) begin
               status = ST_PRESENT;
            end else if (n >= DEPTH) begin
               status = ST_FULL;
            end else begin
               for (int i = n; i > pos; i--) begin
                  book_price[side][i]  = book_price[side][i-1];
                  book_volume[side][i] = book_volume[side][i-1];
               end
               book_price[side][pos]  = price;
               book_volume[side][pos] = volume;
               book_count[side]++;
            end
         end
         OP_CHANGE: begin
            if (found) book_volume[side][pos] = volume;
            else status = ST_ABSENT;
         end
         default: begin
            // erase of an absent price is silently ignored
            if (found) begin
               for (int i = pos; i + 1 < n; i++) begin
                  book_price[side][i]  = book_price[side][i+1];
                  book_volume[side][i] = book_volume[side][i+1];
               end
               book_count[side]--;
            end
         end
      endcase
      if (op != OP_DUMP) push_word(status, side, '0, '0, 1'b0, 1'b1);
   endtask

   // ---------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------

   function automatic int next_gap();
      if (!sender_gaps) return 0;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         return $urandom_range(1, 8);
      end
      return 0;
   endfunction

   // drive one request word and hold it until taken
   task automatic send_word(input op_type op, input logic side,
                            input logic [PRICE_W-1:0] price, input logic [VOL_W-1:0] volume);
      int gap;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_side      <= side;
      req_price     <= price;
      req_volume    <= volume;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book_apply(op, side, price, volume);
      items_sent++;
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every due word has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_words.size() != 0) @(posedge clock);
   endtask

   function automatic logic [PRICE_W-1:0] pick_price(input logic side);
      int r;
      r = $urandom_range(0, 99);
      if (r < 45 && book_count[side] > 0)
         return book_price[side][$urandom_range(0, book_count[side] - 1)];
      if (r < 80) return 32'd1000 + $urandom_range(0, 47);
      if (r < 85) return 32'h0000_0000;
      if (r < 90) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic logic [VOL_W-1:0] pick_volume();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h0000_0000;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic op_type pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return OP_ADD;
      if (r < 55) return OP_CHANGE;
      if (r < 82) return OP_ERASE;
      return OP_DUMP;
   endfunction

   // ---------------------------------------------------------------
   // Receiver stall pattern: switches between none, random and bursty
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_mode  <= STALL_NONE;
         mode_cycles <= 0;
         stall_run   <= 0;
      end else begin
         if (mode_cycles == 0) begin
            stall_mode  <= stall_mode_type'($urandom_range(0, 2));
            mode_cycles <= $urandom_range(50, 300);
         end else begin
            mode_cycles <= mode_cycles - 1;
         end
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: begin
               if (stall_run == 0) begin
                  rsp_stall <= ~rsp_stall;
                  stall_run <= $urandom_range(1, 8);
               end else begin
                  stall_run <= stall_run - 1;
               end
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MAX_MISMATCH_LINES)
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_words
      level_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (due_words.size() == 0) begin
            error_count++;
            if (error_count <= MAX_MISMATCH_LINES)
               $display("%0t: unexpected word, expected none, got status %h price %h",
                        $time, rsp_status, rsp_level_price);
         end else begin
            want = due_words.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("level_side", want.side, rsp_level_side);
            check_field("level_price", want.price, rsp_level_price);
            check_field("level_volume", want.volume, rsp_level_volume);
            check_field("level_valid", want.valid, rsp_level_valid);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // extremes, every operation, every status but full, empty and ordered dumps
   task automatic test_directed();
      sender_gaps = 1'b0;
      send_word(OP_DUMP,   SELL, 32'd0,          32'd0);
      send_word(OP_DUMP,   BUY,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
      send_word(OP_ADD,    SELL, 32'h0000_0000,  32'hFFFF_FFFF);
      send_word(OP_ADD,    SELL, 32'hFFFF_FFFF,  32'h0000_0000);
      send_word(OP_ADD,    SELL, 32'd5000,       32'd1234);
      send_word(OP_ADD,    SELL, 32'd5000,       32'd99);
      send_word(OP_CHANGE, SELL, 32'd5000,       32'd7);
      send_word(OP_CHANGE, SELL, 32'd6000,       32'd8);
      send_word(OP_ERASE,  SELL, 32'd6000,       32'd0);
      send_word(OP_ADD,    BUY,  32'hFFFF_FFFF,  32'd1);
      send_word(OP_ADD,    BUY,  32'h0000_0000,  32'hFFFF_FFFF);
      send_word(OP_ADD,    BUY,  32'd4000,       32'hAAAA_5555);
      send_word(OP_ADD,    BUY,  32'd4200,       32'h5555_AAAA);
      send_word(OP_CHANGE, BUY,  32'h0000_0000,  32'h0000_0000);
      send_word(OP_DUMP,   SELL, 32'd0,          32'd0);
      send_word(OP_DUMP,   BUY,  32'd0,          32'd0);
      // erase the low end, the high end and the middle
      send_word(OP_ERASE,  SELL, 32'h0000_0000,  32'd0);
      send_word(OP_ERASE,  BUY,  32'hFFFF_FFFF,  32'd0);
      send_word(OP_ERASE,  BUY,  32'd4000,       32'd0);
      send_word(OP_DUMP,   SELL, 32'd0,          32'd0);
      send_word(OP_DUMP,   BUY,  32'd0,          32'd0);
   endtask

   // fill one side to capacity, then hit it with a full add, a duplicate, a change and a dump
   task automatic test_fill_side(input logic side);
      sender_gaps = 1'b1;
      while (book_count[side] < DEPTH)
         send_word(OP_ADD, side, $urandom, pick_volume());
      send_word(OP_ADD, side, $urandom, pick_volume());
      send_word(OP_ADD, side, book_price[side][$urandom_range(0, DEPTH - 1)], pick_volume());
      send_word(OP_CHANGE, side, book_price[side][$urandom_range(0, DEPTH - 1)], pick_volume());
      send_word(OP_DUMP, side, $urandom, $urandom);
      // thin it out again so the random mix sees room to grow
      repeat (DEPTH / 2)
         send_word(OP_ERASE, side, book_price[side][$urandom_range(0, book_count[side] - 1)],
                   $urandom);
   endtask

   task automatic test_random_mix(input int count, input bit gaps);
      logic side;
      sender_gaps = gaps;
      repeat (count) begin
         side = 1'($urandom_range(0, 1));
         send_word(pick_op(), side, pick_price(side), pick_volume());
      end
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------

   initial begin
      book_count[SELL] = 0;
      book_count[BUY]  = 0;
      for (int i = 0; i < 4; i++) begin
         op_seen[i]     = 0;
         status_seen[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      wait_for_drain();
      test_fill_side(SELL);
      test_fill_side(BUY);
      wait_for_drain();
      test_random_mix(110, 1'b1);
      test_random_mix(110, 1'b0);
      wait_for_drain();
      test_random_mix(110, 1'b1);
      wait_for_drain();
      repeat (DEPTH + 8) @(posedge clock);

      $display("Sent %0d requests (add %0d, change %0d, erase %0d, dump %0d), checked %0d words",
               items_sent, op_seen[OP_ADD], op_seen[OP_CHANGE], op_seen[OP_ERASE],
               op_seen[OP_DUMP], words_checked);
      $display("Dumped %0d levels; duplicate adds %0d, absent changes %0d, full adds %0d",
               dump_levels, status_seen[ST_PRESENT], status_seen[ST_ABSENT],
               status_seen[ST_FULL]);
      if (error_count == 0 && due_words.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
